@@ rtl/sle_pkg.sv @@
// Shared types, codes and constants for the sorted list engine.
`timescale 1ns / 1ps
package sle_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int GRP_W     = 32;
	localparam int VAL_W     = 32;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_DELETE = 1'b1;

	localparam logic [1:0] ST_DONE      = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_CMP  = 4'b0010,
		S_UPD  = 4'b0100,
		S_RESP = 4'b1000
	} state_t;

	// Broadcast to every cell: apply strobes and the command value.
	typedef struct packed {
		logic                    ins;
		logic                    del;
		logic signed [VAL_W-1:0] value;
	} bcast_t;

endpackage

@@ rtl/sorted_list_engine.sv @@
// Top level: command sequencer, hit reduction and a chain of sorted cells.
// A result passes hit reduction, chain update and the result register after its
// item is accepted; the next item is accepted the cycle after the result register
// loads. The block takes no new item until the sequencer has been round its four
// states back to idle; a stalled result holds it in the result state.
// Reset (arst_n low) empties the store: all valid bits and the count clear.
`timescale 1ns / 1ps
module sorted_list_engine #(
	parameter int DEPTH = sle_pkg::DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             cmd,
	input  logic signed [sle_pkg::VAL_W-1:0] value,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [1:0]                       status,
	output logic [4:0]                       count,
	output logic signed [sle_pkg::VAL_W-1:0] smallest
);
	import sle_pkg::*;

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int NGRP  = (DEPTH + GRP_W - 1) / GRP_W;

	state_t                  state_q;
	logic                    cmd_q;
	logic signed [VAL_W-1:0] value_q;
	logic [CNT_W-1:0]        held_q;
	logic [1:0]              status_q;
	logic [NGRP-1:0]         grp_q;
	logic [NGRP-1:0]         grp_d;
	logic                    out_valid_q;
	logic [1:0]              out_status_q;
	logic [4:0]              out_count_q;
	logic signed [VAL_W-1:0] out_small_q;

	bcast_t                  bc;
	logic signed [VAL_W-1:0] vals [DEPTH];
	logic [DEPTH-1:0]        vlds;
	logic [DEPTH-1:0]        les;
	logic [DEPTH-1:0]        eqs;
	logic [NGRP*GRP_W-1:0]   eq_pad;
	logic                    found;
	logic                    full;
	logic                    out_free;
	logic [CNT_W+4:0]        held_wide;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign status    = out_status_q;
	assign count     = out_count_q;
	assign smallest  = out_small_q;

	assign found    = |grp_q;
	assign full     = (held_q == CNT_W'(DEPTH));
	assign out_free = !out_valid_q || out_ready;
	assign held_wide = {5'b00000, held_q};

	assign bc.value = value_q;
	assign bc.ins   = (state_q == S_UPD) && (cmd_q == CMD_INSERT) && !full;
	assign bc.del   = (state_q == S_UPD) && (cmd_q == CMD_DELETE) && found;

	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			logic signed [VAL_W-1:0] l_val;
			logic                    l_vld;
			logic                    l_le;
			logic signed [VAL_W-1:0] r_val;
			logic                    r_vld;
			if (gi == 0) begin : g_head
				assign l_val = value_q;
				assign l_vld = 1'b1;
				assign l_le  = 1'b1;
			end else begin : g_mid
				assign l_val = vals[gi-1];
				assign l_vld = vlds[gi-1];
				assign l_le  = les[gi-1];
			end
			if (gi == DEPTH - 1) begin : g_tail
				assign r_val = value_q;
				assign r_vld = 1'b0;
			end else begin : g_body
				assign r_val = vals[gi+1];
				assign r_vld = vlds[gi+1];
			end
			sle_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.bc        (bc),
				.left_val  (l_val),
				.left_vld  (l_vld),
				.left_le   (l_le),
				.right_val (r_val),
				.right_vld (r_vld),
				.val       (vals[gi]),
				.vld       (vlds[gi]),
				.le        (les[gi]),
				.eq        (eqs[gi])
			);
		end
	endgenerate

	always_comb begin
		eq_pad = '0;
		eq_pad[DEPTH-1:0] = eqs;
		for (int g = 0; g < NGRP; g++) begin
			grp_d[g] = |eq_pad[g*GRP_W +: GRP_W];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			cmd_q   <= cmd;
			value_q <= value;
		end
		if (state_q == S_CMP) begin
			grp_q <= grp_d;
		end
		if (state_q == S_UPD) begin
			if (cmd_q == CMD_INSERT) begin
				status_q <= full ? ST_FULL : ST_DONE;
			end else begin
				status_q <= found ? ST_DONE : ST_NOT_FOUND;
			end
		end
		if (state_q == S_RESP && out_free) begin
			out_status_q <= status_q;
			out_count_q  <= held_wide[4:0];
			out_small_q  <= vlds[0] ? vals[0] : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			held_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// load a new result, or drop the one just taken
			if (state_q == S_RESP && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					state_q <= S_UPD;
				end
				S_UPD: begin
					if (bc.ins) begin
						held_q <= held_q + 1'b1;
					end else if (bc.del) begin
						held_q <= held_q - 1'b1;
					end
					state_q <= S_RESP;
				end
				S_RESP: begin
					// hold until the result register is free
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= CNT_W'(DEPTH))
		else $error("held count exceeds depth");

	a_vld_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(vlds) == int'(held_q))
		else $error("cell valid bits disagree with held count");

	a_del_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		bc.del |-> (held_q != '0))
		else $error("delete applied to an empty store");

	a_upd_resp: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UPD) |=> (state_q == S_RESP))
		else $error("update not followed by result stage");
`endif

endmodule

@@ rtl/sle_cell.sv @@
// One storage cell of the sorted chain: holds a value and its valid bit.
`timescale 1ns / 1ps
module sle_cell (
	input  logic                               clk,
	input  logic                               arst_n,
	input  sle_pkg::bcast_t                    bc,
	input  logic signed [sle_pkg::VAL_W-1:0]   left_val,
	input  logic                               left_vld,
	input  logic                               left_le,
	input  logic signed [sle_pkg::VAL_W-1:0]   right_val,
	input  logic                               right_vld,
	output logic signed [sle_pkg::VAL_W-1:0]   val,
	output logic                               vld,
	output logic                               le,
	output logic                               eq
);
	import sle_pkg::*;

	logic signed [VAL_W-1:0] val_q;
	logic                    vld_q;
	logic                    ge;

	assign val = val_q;
	assign vld = vld_q;
	assign le  = vld_q && (val_q <= bc.value);
	assign ge  = vld_q && (val_q >= bc.value);
	assign eq  = vld_q && (val_q == bc.value);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (bc.ins) begin
			vld_q <= vld_q || left_vld;
		end else if (bc.del && ge) begin
			vld_q <= right_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (bc.ins && !le) begin
			// first cell past the insert point takes the value, later ones shift right
			val_q <= left_le ? bc.value : left_val;
		end else if (bc.del && ge) begin
			val_q <= right_val;
		end
	end

endmodule

@@ dv/sorted_list_engine_test.sv @@
// Self-checking testbench for the sorted list engine: directed and random commands.
`timescale 1ns / 1ps
module sorted_list_engine_test;
	import sle_pkg::*;

	localparam int STORE_DEPTH    = DEPTH_DEF;
	localparam int RANDOM_ITEMS   = 1825;
	localparam int QUIET_FROM     = RANDOM_ITEMS - 250;
	localparam int HOLD_AT        = 400;
	localparam int LONG_HOLD      = 200;
	localparam int DRAIN_CYCLES   = 20;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;

	typedef struct packed {
		logic [1:0]              status;
		logic [4:0]              count;
		logic signed [VAL_W-1:0] smallest;
	} result_t;

	// Sorted store predictor plus the queue of results still owed by the block.
	class sorted_store_model;
		logic signed [VAL_W-1:0] vals [STORE_DEPTH];
		int held;
		result_t expected_results[$];
		int mismatches;

		function new();
			held = 0;
			mismatches = 0;
		endfunction

		function void note_command(logic c, logic signed [VAL_W-1:0] v);
			result_t r;
			int pos;
			int i;
			r.status = ST_DONE;
			pos = 0;
			if (c == CMD_INSERT) begin
				if (held >= STORE_DEPTH) begin
					r.status = ST_FULL;
				end else begin
					// land after every equal value
					while (pos < held && vals[pos] <= v)
						pos++;
					for (i = held; i > pos; i--)
						vals[i] = vals[i-1];
					vals[pos] = v;
					held++;
				end
			end else begin
				while (pos < held && vals[pos] != v)
					pos++;
				if (pos >= held) begin
					r.status = ST_NOT_FOUND;
				end else begin
					for (i = pos; i + 1 < held; i++)
						vals[i] = vals[i+1];
					held--;
				end
			end
			r.count = 5'(held);
			r.smallest = (held > 0) ? vals[0] : '0;
			expected_results.push_back(r);
		endfunction

		function void check_result(logic [1:0] st, logic [4:0] cnt,
				logic signed [VAL_W-1:0] sm);
			result_t e;
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: status %0d count %0d smallest %0d",
						st, cnt, sm);
				return;
			end
			e = expected_results.pop_front();
			if (e.status !== st || e.count !== cnt || e.smallest !== sm) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: status %0d/%0d count %0d/%0d smallest %0d/%0d (exp/got)",
						e.status, st, e.count, cnt, e.smallest, sm);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic cmd;
	logic signed [VAL_W-1:0] value;
	logic out_valid;
	logic out_ready;
	logic [1:0] status;
	logic [4:0] count;
	logic signed [VAL_W-1:0] smallest;

	sorted_store_model store = new();
	int items_sent = 0;
	int items_noted = 0;
	int idle_cycles = 0;
	bit tx_idle_on = 1'b1;
	bit rx_idle_on = 1'b1;
	bit hold_req = 1'b0;

	sorted_list_engine #(.DEPTH(STORE_DEPTH)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd(cmd),
		.value(value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.count(count),
		.smallest(smallest)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Check the result first, then predict the accepted item, in one process.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				store.check_result(status, count, smallest);
			if (in_valid && in_ready) begin
				store.note_command(cmd, value);
				items_noted++;
			end
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	initial begin : receiver
		int gap;
		gap = 0;
		out_ready = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				// stall long enough to back the block up into its input
				hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (gap > 0) begin
				out_ready <= 1'b0;
				gap--;
			end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
				gap = $urandom_range(0, 2);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic send_item(logic c, logic signed [VAL_W-1:0] v);
		in_valid <= 1'b1;
		cmd <= c;
		value <= v;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		items_sent++;
		// let the predictor catch up before the next item is picked
		wait (items_noted == items_sent);
		if (tx_idle_on && $urandom_range(0, 2) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	initial begin
		int n;
		int k;
		int ins_pct;
		logic c;
		logic signed [VAL_W-1:0] v;
		arst_n = 1'b0;
		in_valid = 1'b0;
		cmd = CMD_INSERT;
		value = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty store, extremes, duplicates, absent value, full store
		send_item(CMD_DELETE, 32'sd5);
		send_item(CMD_INSERT, VAL_MAX);
		send_item(CMD_INSERT, VAL_MIN);
		send_item(CMD_INSERT, 32'sd0);
		send_item(CMD_INSERT, 32'sd0);
		send_item(CMD_INSERT, -32'sd1);
		send_item(CMD_DELETE, 32'sd0);
		send_item(CMD_DELETE, 32'sd77);
		send_item(CMD_DELETE, VAL_MIN);
		send_item(CMD_INSERT, -32'sd1);
		for (k = 0; k < 12; k++)
			send_item(CMD_INSERT, 32'(k * 1000 - 5000));
		send_item(CMD_INSERT, 32'sd42);
		send_item(CMD_DELETE, VAL_MAX);
		send_item(CMD_DELETE, -32'sd1);

		ins_pct = 50;
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 120 == 0) begin
				case ($urandom_range(0, 4))
					0: ins_pct = 25;
					1, 2: ins_pct = 50;
					3: ins_pct = 60;
					default: ins_pct = 85;
				endcase
				tx_idle_on = (n < QUIET_FROM) && ($urandom_range(0, 2) != 0);
				rx_idle_on = (n < QUIET_FROM) && ($urandom_range(0, 2) != 0);
			end
			if (n == QUIET_FROM) begin
				tx_idle_on = 1'b0;
				rx_idle_on = 1'b0;
			end
			if (n == HOLD_AT)
				hold_req = 1'b1;

			c = ($urandom_range(0, 99) < ins_pct) ? CMD_INSERT : CMD_DELETE;
			k = $urandom_range(0, 9);
			if (c == CMD_DELETE && store.held > 0 && k < 6)
				v = store.vals[$urandom_range(0, store.held - 1)];
			else if (k < 5)
				v = 32'($urandom_range(0, 6)) - 32'sd3;
			else if (k < 8)
				v = $urandom;
			else begin
				case ($urandom_range(0, 3))
					0: v = VAL_MIN;
					1: v = VAL_MIN + 32'sd1;
					2: v = VAL_MAX - 32'sd1;
					default: v = VAL_MAX;
				endcase
			end
			send_item(c, v);
		end

		in_valid <= 1'b0;
		while (store.expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (store.mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
